/* hw/rtl/bbd_pkg.sv */
// Package for the bilinear Bayer demosaic: widths, reset values, register
// indexes and the job record passed from the line-store front end to the pixel unit.
// No dependencies.
package bbd_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam int SAMPLE_W   = 8;
    localparam int COLUMN_W   = 3 * SAMPLE_W;
    localparam int AW_W       = 11;
    localparam int AH_W       = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [AW_W-1:0] ACTIVE_WIDTH_RST  = 11'd640;
    localparam logic [AH_W-1:0] ACTIVE_HEIGHT_RST = 12'd480;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    // raw column: bits 7:0 row y-2, 15:8 row y-1, 23:16 row y
    typedef logic [COLUMN_W-1:0] column_t;

    typedef struct packed {
        column_t col_l;
        column_t col_c;
        column_t col_r;
        logic    end_row;
        logic    last_row;
        logic    top_row;
        logic    y_odd;
        logic    x_odd;
    } job_t;

endpackage

/* hw/rtl/bbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bbd_front.sv */
// Front end: column/row counters, the two raw line stores (read at accept,
// written back one stage later) and the three-column window. Uses bbd_pkg, bbd_ram.
module bbd_front
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [AW_W-1:0] active_width,
    input  logic [AH_W-1:0] active_height,
    input  logic            in_valid,
    output logic            in_ready,
    input  sample_t         in_sample,
    output logic            job_valid,
    input  logic            job_ready,
    output job_t            job
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > AW_W) ? CW + 1 : AW_W;

    logic [WW-1:0]   aw_ext;
    logic [CW-1:0]   last_col;
    logic [AH_W-1:0] last_row_idx;
    logic            end_row;
    logic            last_row;
    logic            accept;

    logic [CW-1:0]   col_reg, col_next;
    logic [AH_W-1:0] row_reg, row_next;

    // stage B: read data from the stores is valid here
    logic            b_valid_reg, b_valid_next;
    sample_t         b_sample_reg;
    logic [CW-1:0]   b_col_reg;
    logic            b_end_reg, b_last_reg, b_top_reg, b_yodd_reg, b_xone_reg, b_has_reg;

    logic [2*COLUMN_W-1:0] window_reg;
    sample_t         older_rd, newer_rd;
    column_t         cur, prev, pprev;
    logic            b_adv;

    assign aw_ext = WW'(active_width);

    always_comb
    begin
        if (active_width < AW_W'(2))
        begin
            last_col = CW'(1);
        end
        else if (aw_ext > WW'(MAX_WIDTH))
        begin
            last_col = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CW'(aw_ext - WW'(1));
        end
    end

    assign last_row_idx = (active_height < AH_W'(2)) ? AH_W'(1) : active_height - AH_W'(1);
    assign end_row      = (col_reg >= last_col);
    assign last_row     = (row_reg >= last_row_idx);
    assign accept       = in_valid & in_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + AH_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    bbd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (b_adv),
        .waddr (b_col_reg),
        .wdata (newer_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (older_rd)
    );

    bbd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (b_adv),
        .waddr (b_col_reg),
        .wdata (b_sample_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (newer_rd)
    );

    assign cur   = {b_sample_reg, newer_rd, older_rd};
    assign prev  = window_reg[COLUMN_W-1:0];
    assign pprev = window_reg[2*COLUMN_W-1:COLUMN_W];

    // samples with no result pass through without waiting on the pixel unit
    assign b_adv     = b_valid_reg & (~b_has_reg | job_ready);
    assign job_valid = b_valid_reg & b_has_reg;
    assign in_ready  = ~b_valid_reg | b_adv;

    assign job.col_l    = b_xone_reg ? cur : pprev;
    assign job.col_c    = prev;
    assign job.col_r    = cur;
    assign job.end_row  = b_end_reg;
    assign job.last_row = b_last_reg;
    assign job.top_row  = b_top_reg;
    assign job.y_odd    = b_yodd_reg;
    assign job.x_odd    = b_col_reg[0];

    assign b_valid_next = accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            window_reg  <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
            if (b_adv)
            begin
                window_reg <= {prev, cur};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sample_reg <= in_sample;
            b_col_reg    <= col_reg;
            b_end_reg    <= end_row;
            b_last_reg   <= last_row;
            b_top_reg    <= (row_reg == AH_W'(1));
            b_yodd_reg   <= row_reg[0];
            b_xone_reg   <= (col_reg == CW'(1));
            b_has_reg    <= (row_reg != '0) && (col_reg != '0);
        end
    end

endmodule

/* hw/rtl/bbd_pixel.sv */
// Pixel unit: walks the one to four pixels of a job, interpolates one per
// cycle unless stalled and holds it in the output register. Uses bbd_pkg.
module bbd_pixel
    import bbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t red,
    output sample_t green,
    output sample_t blue,
    output logic    last_in_run,
    output logic    frame_done
);

    // step bit 1: right-edge pixel, bit 0: pixel of the bottom row
    logic       job_valid_reg;
    job_t       job_reg;
    logic [1:0] step_reg, step_next;
    logic       done;
    logic       adv;

    logic       out_valid_reg;
    sample_t    red_reg, green_reg, blue_reg;
    logic       last_reg, frame_reg;

    column_t    cl, cc, cr;
    column_t    vl, vc, vr;
    logic       lower, edge_px, py_odd, px_odd;
    logic [8:0] hm, vm, dl, dr, dg, gm;
    sample_t    red_c, green_c, blue_c;

    // rows 0..2 of the window as {below, centre, above}; mirrors at the frame edges
    function automatic column_t pick_rows(column_t col, logic bottom, logic top);
        column_t v;
        if (bottom)
        begin
            v = {col[15:8], col[23:16], col[15:8]};
        end
        else
        begin
            v = {col[23:16], col[15:8], top ? col[23:16] : col[7:0]};
        end
        return v;
    endfunction

    always_comb
    begin
        lower = step_reg[0];
        edge_px = step_reg[1];
        done = 1'b1;
        step_next = step_reg;
        if (!lower && job_reg.last_row)
        begin
            step_next = {edge_px, 1'b1};
            done = 1'b0;
        end
        else if (!edge_px && job_reg.end_row)
        begin
            step_next = 2'b10;
            done = 1'b0;
        end
    end

    assign cl = edge_px ? job_reg.col_c : job_reg.col_l;
    assign cc = edge_px ? job_reg.col_r : job_reg.col_c;
    assign cr = edge_px ? job_reg.col_c : job_reg.col_r;

    assign vl = pick_rows(cl, lower, job_reg.top_row);
    assign vc = pick_rows(cc, lower, job_reg.top_row);
    assign vr = pick_rows(cr, lower, job_reg.top_row);

    assign py_odd = lower ? job_reg.y_odd : ~job_reg.y_odd;
    assign px_odd = edge_px ? job_reg.x_odd : ~job_reg.x_odd;

    assign hm = ({1'b0, vl[15:8]} + {1'b0, vr[15:8]}) >> 1;
    assign vm = ({1'b0, vc[7:0]}  + {1'b0, vc[23:16]}) >> 1;
    assign dl = ({1'b0, vl[7:0]}  + {1'b0, vl[23:16]}) >> 1;
    assign dr = ({1'b0, vr[7:0]}  + {1'b0, vr[23:16]}) >> 1;
    assign dg = (dl + dr) >> 1;
    assign gm = (hm + vm) >> 1;

    always_comb
    begin
        case ({py_odd, px_odd})
            2'b00:
            begin
                red_c = hm[7:0]; green_c = vc[15:8]; blue_c = vm[7:0];
            end
            2'b01:
            begin
                red_c = vc[15:8]; green_c = gm[7:0]; blue_c = dg[7:0];
            end
            2'b10:
            begin
                red_c = dg[7:0]; green_c = gm[7:0]; blue_c = vc[15:8];
            end
            default:
            begin
                red_c = vm[7:0]; green_c = vc[15:8]; blue_c = hm[7:0];
            end
        endcase
    end

    assign adv       = job_valid_reg & (~out_valid_reg | out_ready);
    assign job_ready = ~job_valid_reg | (adv & done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready && job_valid)
            begin
                job_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (adv && done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                step_reg <= step_next;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            job_reg <= job;
        end
        if (adv)
        begin
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            last_reg  <= done;
            frame_reg <= edge_px & lower;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign last_in_run = last_reg;
    assign frame_done  = frame_reg;

endmodule

/* hw/rtl/bayer_bilinear_demosaic.sv */
// Top level of the bilinear Bayer demosaic (GRBG): configuration registers,
// line-store front end and pixel unit. Uses bbd_pkg, bbd_front, bbd_pixel.
//
// - s_axis: one raw 8-bit sample per beat, raster order, GRBG from the origin.
//   m_axis: one RGB pixel per beat; tlast marks the final pixel caused by a
//   sample, tuser the frame's last pixel (W-1, H-1).
// - Output lags input by one line and one pixel: row 0 and column 0 give
//   nothing, and a sample at (x, y) gives pixel (x-1, y-1). The last column
//   adds (W-1, y-1); on the last row each pixel of row H-2 is followed by the
//   one below it, so the frame's final sample gives four.
// - Path: an accepted sample is registered in the read stage (store read),
//   then in the job register; its pixel is interpolated into the output register.
// - Throughput: while m_axis is not stalled, one sample per cycle as long as each
//   makes at most one pixel; the pixel unit makes one pixel per cycle, so row ends,
//   last-row samples and the final sample hold back the samples behind them.
// - Line stores are read at accept and written back as the sample leaves the
//   read stage; adjacent samples never share a column.
// - Reset clears counters, window and control; store contents stay undefined.
// - A stalled receiver holds the output register; the input is refused once
//   the stage behind it is full. Write cfg_* only while the block is idle.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // raw samples
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] raw_sample
    // pixels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                  m_axis_tlast,   // last_in_run
    output logic [0:0]            m_axis_tuser    // [0] frame_done
);

    logic [AW_W-1:0] width_reg;
    logic [AH_W-1:0] height_reg;

    logic            job_valid;
    logic            job_ready;
    job_t            job;
    sample_t         red, green, blue;
    logic            frame_done;

    // register writes; the user must change config only while the stream is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ACTIVE_WIDTH_RST;
            height_reg <= ACTIVE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_WIDTH:  width_reg  <= cfg_data[AW_W-1:0];
                REG_ACTIVE_HEIGHT: height_reg <= cfg_data[AH_W-1:0];
                default:           ;
            endcase
        end
    end

    bbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_width  (width_reg),
        .active_height (height_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_sample     (s_axis_tdata),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job)
    );

    bbd_pixel u_pixel (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_in_run (m_axis_tlast),
        .frame_done  (frame_done)
    );

    assign m_axis_tdata    = {blue, green, red};
    assign m_axis_tuser[0] = frame_done;

endmodule
